FILE: design/cics_pkg.sv
// ----------------------------------------------------------------------------
// cics_pkg
// Shared types, register indexes and the tangent table generator for the
// Cauchy inverse-CDF sampler.
// ----------------------------------------------------------------------------
`default_nettype none

package cics_pkg;

  typedef enum logic {
    REG_LOCATION = 1'b0,
    REG_SCALE    = 1'b1
  } cfg_reg_e;

  localparam int unsigned DivSteps = 34;

  localparam logic [63:0] PiQ60 = 64'h3243F6A8885A308D;
  localparam logic [63:0] Q30One = 64'd1 << 30;

  // Item state that travels through the divider stages
  typedef struct packed {
    logic                vld;
    logic                neg;
    logic                far;
    logic                pole;
    logic                ovf;
    logic [31:0]         nmag;
    logic [61:0]         rem;
    logic [31:0]         den;
    logic [DivSteps-1:0] quo;
  } div_t;

  // truncating long division, only evaluated while the table is built
  function automatic logic [63:0] udiv64(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] q;
    logic [64:0] r;
    q = '0;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      r = {r[63:0], a[i]};
      if (r >= {1'b0, b}) begin
        r    = r - {1'b0, b};
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  // tan(k*pi/(4n)) in Q2.30, built from truncating Taylor series
  function automatic logic [31:0] tan_entry(input logic [63:0] k, input logic [63:0] n);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] s;
    logic [63:0] c;
    logic [63:0] r;
    x  = udiv64(k * (PiQ60 >> 16), 64'd4 * n) >> 14;
    x2 = (x * x) >> 30;
    s  = Q30One;
    c  = Q30One;
    for (int j = 5; j >= 1; j--) begin
      s = Q30One - udiv64((x2 * s) >> 30, 64'(2 * j) * 64'(2 * j + 1));
    end
    for (int j = 6; j >= 1; j--) begin
      c = Q30One - udiv64((x2 * c) >> 30, 64'(2 * j - 1) * 64'(2 * j));
    end
    s = (x * s) >> 30;
    if (c == 64'd0) begin
      r = Q30One;
    end else begin
      r = udiv64(s << 30, c);
    end
    return r[31:0];
  endfunction

endpackage

`default_nettype wire

FILE: design/cics_div_pipe.sv
// ----------------------------------------------------------------------------
// cics_div_pipe
// Restoring divider, one quotient bit per register stage.
// ----------------------------------------------------------------------------
`default_nettype none

module cics_div_pipe
  import cics_pkg::*;
(
  input  wire  logic clk_i,
  input  wire  logic rst_ni,
  input  wire  logic en_i,
  input  div_t       din_i,
  output div_t       dout_o
);

  div_t st_q [DivSteps+1];

  assign st_q[0] = din_i;

  for (genvar i = 0; i < DivSteps; i++) begin : g_step
    localparam int unsigned Bit = DivSteps - 1 - i;
    logic [65:0] sub;
    logic [65:0] trial;
    div_t        nxt_d;

    always_comb begin
      nxt_d      = st_q[i];
      sub        = 66'(st_q[i].den) << Bit;
      trial      = 66'(st_q[i].rem) - sub;
      if (66'(st_q[i].rem) >= sub) begin
        nxt_d.rem      = trial[61:0];
        nxt_d.quo[Bit] = 1'b1;
      end else begin
        nxt_d.quo[Bit] = 1'b0;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        st_q[i+1] <= '0;
      end else if (en_i) begin
        st_q[i+1] <= nxt_d;
      end
    end
  end

  assign dout_o = st_q[DivSteps];

endmodule

`default_nettype wire

FILE: design/cauchy_inverse_cdf_sampler.sv
// ----------------------------------------------------------------------------
// cauchy_inverse_cdf_sampler
// Uniform word in, Cauchy sample x = scale * tan(pi * (u - 1/2)) + location out.
// ----------------------------------------------------------------------------
// Fully pipelined: one transfer per cycle in and out while the output is not
// stalled. An item passes 6 front stages (angle, table lookup, interpolation
// and scaling), one range-check stage, 34 divider stages and one output
// register. The 34-stage restoring divider sets the depth; it serves the
// reciprocal path used for angles beyond pi/4. An output stall holds the
// whole pipeline. Configuration writes are meant for idle periods only.
`default_nettype none

module cauchy_inverse_cdf_sampler
  import cics_pkg::*;
#(
  parameter int unsigned TAN_TABLE_ENTRIES = 1024
) (
  input  wire  logic        clk_i,
  input  wire  logic        rst_ni,
  input  wire  logic        cfg_we_i,
  input  wire  logic        cfg_idx_i,
  input  wire  logic [31:0] cfg_wdata_i,
  input  wire  logic        in_valid_i,
  output logic              in_ready_o,
  input  wire  logic [31:0] uniform_fraction_i,
  output logic              out_valid_o,
  input  wire  logic        out_ready_i,
  output logic [31:0]       sample_o,
  output logic              saturated_o
);

  localparam int unsigned N  = TAN_TABLE_ENTRIES;
  localparam int unsigned KW = $clog2(N + 1);
  localparam int unsigned PW = 30 + KW;

  typedef logic [31:0] tan_tab_t [N+1];

  function automatic tan_tab_t build_tab();
    tan_tab_t t;
    for (int k = 0; k <= N; k++) begin
      t[k] = tan_entry(64'(k), 64'(N));
    end
    return t;
  endfunction

  localparam tan_tab_t TanTab = build_tab();

  // configuration
  logic signed [31:0] location_q;
  logic [30:0]        scale_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      location_q <= '0;
      scale_q    <= 31'd65536;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_LOCATION: location_q <= cfg_wdata_i;
        REG_SCALE:    scale_q    <= (cfg_wdata_i[30:0] == '0) ? 31'd1 : cfg_wdata_i[30:0];
        default: ;
      endcase
    end
  end

  logic en;
  logic out_valid_q;
  assign en         = !out_valid_q || out_ready_i;
  assign in_ready_o = en;

  // valid bits of front stages
  logic [6:1] vld_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[5:1], in_valid_i};
    end
  end

  // stage 1: signed angle offset, branch select
  logic        neg1_q, far1_q;
  logic [30:0] d1_q;
  logic [31:0] t_abs;
  logic        t_neg;
  assign t_neg = !uniform_fraction_i[31];
  assign t_abs = t_neg ? (32'h8000_0000 - uniform_fraction_i)
                       : {1'b0, uniform_fraction_i[30:0]};

  always_ff @(posedge clk_i) begin
    if (en) begin
      neg1_q <= t_neg;
      far1_q <= (t_abs > 32'h4000_0000);
      d1_q   <= (t_abs > 32'h4000_0000) ? 31'(32'h8000_0000 - t_abs) : t_abs[30:0];
    end
  end

  // stage 2: table position
  logic          neg2_q, far2_q;
  logic [KW-1:0] k2_q;
  logic [29:0]   f2_q;
  logic [PW-1:0] pos;
  assign pos = PW'(d1_q) * PW'(N);

  always_ff @(posedge clk_i) begin
    if (en) begin
      neg2_q <= neg1_q;
      far2_q <= far1_q;
      k2_q   <= pos[PW-1:30];
      f2_q   <= pos[29:0];
    end
  end

  // stage 3: table reads
  logic          neg3_q, far3_q;
  logic [29:0]   f3_q;
  logic [31:0]   lo3_q, hi3_q;
  logic [KW-1:0] k_hi;
  assign k_hi = (32'(k2_q) >= N) ? KW'(N) : k2_q + KW'(1);

  always_ff @(posedge clk_i) begin
    if (en) begin
      neg3_q <= neg2_q;
      far3_q <= far2_q;
      f3_q   <= (32'(k2_q) >= N) ? 30'd0 : f2_q;
      lo3_q  <= TanTab[(32'(k2_q) >= N) ? KW'(N) : k2_q];
      hi3_q  <= TanTab[k_hi];
    end
  end

  // stage 4: slope times fraction
  logic        neg4_q, far4_q;
  logic [31:0] lo4_q;
  logic [61:0] ip4_q;
  logic [31:0] diff;
  assign diff = (hi3_q < lo3_q) ? 32'd0 : hi3_q - lo3_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      neg4_q <= neg3_q;
      far4_q <= far3_q;
      lo4_q  <= lo3_q;
      ip4_q  <= 62'(diff) * 62'(f3_q);
    end
  end

  // stage 5: interpolated tangent
  logic        neg5_q, far5_q;
  logic [31:0] tn5_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      neg5_q <= neg4_q;
      far5_q <= far4_q;
      tn5_q  <= lo4_q + ip4_q[61:30];
    end
  end

  // stage 6: near product and far numerator
  logic        neg6_q, far6_q, pole6_q;
  logic [31:0] tn6_q;
  logic [62:0] np6_q;
  logic [61:0] num6_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      neg6_q  <= neg5_q;
      far6_q  <= far5_q;
      pole6_q <= far5_q && (tn5_q == '0);
      tn6_q   <= tn5_q;
      np6_q   <= 63'(scale_q) * 63'(tn5_q);
      num6_q  <= {1'b0, scale_q, 30'd0} + 62'(tn5_q >> 1);
    end
  end

  // range check and divider entry
  div_t        dv_d, dv_q, dv_out;
  logic [62:0] np_rnd;
  assign np_rnd = np6_q + 63'(32'h2000_0000);

  always_comb begin
    dv_d      = '0;
    dv_d.vld  = vld_q[6];
    dv_d.neg  = neg6_q;
    dv_d.far  = far6_q;
    dv_d.pole = pole6_q;
    dv_d.nmag = np_rnd[61:30];
    dv_d.den  = tn6_q;
    dv_d.ovf  = {4'd0, num6_q} >= ({34'd0, tn6_q} << DivSteps);
    dv_d.rem  = num6_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_q <= '0;
    end else if (en) begin
      dv_q <= dv_d;
    end
  end

  cics_div_pipe u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .din_i  (dv_q),
    .dout_o (dv_out)
  );

  // final sum and clamp
  logic [34:0]        mag;
  logic signed [35:0] sum;
  logic [31:0]        smp_d;
  logic               sat_d;

  always_comb begin
    if (!dv_out.far) begin
      mag = 35'(dv_out.nmag);
    end else if (dv_out.ovf) begin
      mag = 35'd1 << DivSteps;
    end else begin
      mag = 35'(dv_out.quo);
    end
    sum = dv_out.neg ? (36'(location_q) - $signed({1'b0, mag}))
                     : (36'(location_q) + $signed({1'b0, mag}));
    if (dv_out.pole) begin
      smp_d = dv_out.neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
      sat_d = 1'b1;
    end else if (sum > 36'sh0_7FFF_FFFF) begin
      smp_d = 32'h7FFF_FFFF;
      sat_d = 1'b1;
    end else if (sum < -36'sh0_8000_0000) begin
      smp_d = 32'h8000_0000;
      sat_d = 1'b1;
    end else begin
      smp_d = sum[31:0];
      sat_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= dv_out.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sample_o    <= smp_d;
      saturated_o <= sat_d;
    end
  end

  assign out_valid_o = out_valid_q;

`ifndef NO_ASSERTIONS
  a_sat_extreme: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && saturated_o |-> (sample_o == 32'h7FFF_FFFF || sample_o == 32'h8000_0000))
    else $error("saturated result not at an extreme");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(vld_q) && $stable(dv_q.vld))
    else $error("pipeline moved during output stall");

  a_pole_far: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dv_q.vld && dv_q.pole |-> dv_q.far)
    else $error("pole flagged on near branch");

  a_scale_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    scale_q != '0)
    else $error("scale register holds zero");
`endif

endmodule

`default_nettype wire
